// ----- hw/rtl/stlm_pkg.sv -----
// sorted two-list merge: shared constants, types and helper functions
// used by the controller, datapath and top level; no dependencies
`default_nettype none

package stlm_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int VALUE_WIDTH = 32;
   localparam int FIELD_WIDTH = 32;
   localparam int PTR_WIDTH   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_WIDTH   = $clog2(QUEUE_DEPTH + 1);

   typedef logic [PTR_WIDTH-1:0]          ptr_type;
   typedef logic [CNT_WIDTH-1:0]          cnt_type;
   typedef logic signed [VALUE_WIDTH-1:0] elem_type;
   typedef logic signed [FIELD_WIDTH-1:0] field_type;

   typedef enum logic [1:0] {
      ST_ELEMENT    = 2'd0,
      ST_DROPPED    = 2'd1,
      ST_AFTER_END  = 2'd2,
      ST_BOTH_EMPTY = 2'd3
   } status_type;

   // controller to datapath
   typedef struct packed {
      logic accept;
      logic send_status;
      logic emit;
      logic send_close;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic out_free;
      logic has_pend;
      logic can_emit;
      logic close;
      logic more_after_pop;
   } sts_type;

   function automatic ptr_type next_ptr(input ptr_type p);
      ptr_type r;
      if (p == ptr_type'(QUEUE_DEPTH - 1)) begin
         r = '0;
      end else begin
         r = p + ptr_type'(1);
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/sorted_two_list_merge_core.sv -----
// sorted two-list merge top level: controller plus datapath
// a transfer is taken in the idle state; its results are registered from the status state,
//    from the emit state after each queue ram read (compare and pop), and from the close state
//    for a closing status; only one item is in work at a time, and output stalls hold these states
// reset: synchronous, clears pointers, counts, end bits, controller and output valid
// queue contents are not cleared; only occupied entries are ever used
`default_nettype none

module sorted_two_list_merge_core (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic                req_which_list,
   input  wire stlm_pkg::field_type req_value,
   input  wire logic                req_is_last,
   input  wire logic                req_only_end,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output stlm_pkg::field_type      rsp_merged_value,
   output logic                     rsp_from_list,
   output logic [1:0]               rsp_status,
   output logic                     rsp_merge_done,
   output logic                     rsp_run_last
);

   stlm_pkg::cmd_type cmd;
   stlm_pkg::sts_type sts;

   stlm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   stlm_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_which_list   (req_which_list),
      .req_value        (req_value),
      .req_is_last      (req_is_last),
      .req_only_end     (req_only_end),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_merged_value (rsp_merged_value),
      .rsp_from_list    (rsp_from_list),
      .rsp_status       (rsp_status),
      .rsp_merge_done   (rsp_merge_done),
      .rsp_run_last     (rsp_run_last)
   );

   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_merge_done |-> rsp_run_last)
      else $error("merge done without run end");

   a_status_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != stlm_pkg::ST_ELEMENT)
      |-> (rsp_merged_value == '0) && !rsp_from_list)
      else $error("status result carries element data");

   a_emit_allowed: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> sts.can_emit && sts.out_free)
      else $error("pop without an eligible head");

   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second transfer taken while item in work");

endmodule

`default_nettype wire

// ----- hw/rtl/stlm_ram.sv -----
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module stlm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  wire logic                                      clock,
   input  wire logic                                      wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                          wr_data,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

// ----- hw/rtl/stlm_ctrl.sv -----
// sorted two-list merge controller state machine
// depends on stlm_pkg for command and status structs
`default_nettype none

module stlm_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire stlm_pkg::sts_type sts,
   output stlm_pkg::cmd_type      cmd
);

   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_STATUS = 5'b00010,
      S_READ   = 5'b00100,
      S_EMIT   = 5'b01000,
      S_CLOSE  = 5'b10000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            cmd.accept = req_valid;
            if (req_valid) begin
               state_in = S_STATUS;
            end
         end
         S_STATUS: begin
            if (!sts.has_pend || sts.out_free) begin
               cmd.send_status = sts.has_pend;
               priority if (sts.can_emit) begin
                  state_in = S_READ;
               end else if (sts.close) begin
                  state_in = S_CLOSE;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_READ: begin
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               state_in = sts.more_after_pop ? S_READ : S_IDLE;
            end
         end
         S_CLOSE: begin
            if (sts.out_free) begin
               cmd.send_close = 1'b1;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);

endmodule

`default_nettype wire

// ----- hw/rtl/stlm_datapath.sv -----
// sorted two-list merge datapath: two queues, pointers, counts, end bits,
// head compare and output register; depends on stlm_pkg and stlm_ram
`default_nettype none

module stlm_datapath (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire stlm_pkg::cmd_type     cmd,
   output stlm_pkg::sts_type          sts,
   input  wire logic                  req_which_list,
   input  wire stlm_pkg::field_type   req_value,
   input  wire logic                  req_is_last,
   input  wire logic                  req_only_end,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output stlm_pkg::field_type        rsp_merged_value,
   output logic                       rsp_from_list,
   output logic [1:0]                 rsp_status,
   output logic                       rsp_merge_done,
   output logic                       rsp_run_last
);

   stlm_pkg::ptr_type    rd_ff [2];
   stlm_pkg::ptr_type    rd_in [2];
   stlm_pkg::ptr_type    wr_ff [2];
   stlm_pkg::ptr_type    wr_in [2];
   stlm_pkg::cnt_type    cnt_ff [2];
   stlm_pkg::cnt_type    cnt_in [2];
   logic [1:0]           ended_ff;
   logic [1:0]           ended_in;
   stlm_pkg::status_type pend_ff;
   stlm_pkg::status_type pend_in;

   logic                 out_valid_ff;
   logic                 out_valid_in;
   stlm_pkg::field_type  out_value_ff;
   stlm_pkg::field_type  out_value_in;
   logic                 out_from_ff;
   logic                 out_from_in;
   stlm_pkg::status_type out_status_ff;
   stlm_pkg::status_type out_status_in;
   logic                 out_done_ff;
   logic                 out_done_in;
   logic                 out_last_ff;
   logic                 out_last_in;

   logic [1:0]           wr_en;
   stlm_pkg::elem_type   wr_data;
   stlm_pkg::elem_type   head [2];

   logic                 has_a;
   logic                 has_b;
   logic                 src;
   logic                 after_a;
   logic                 after_b;
   logic                 can_emit;
   logic                 close;
   logic                 more_after_pop;
   logic                 out_free;
   logic                 list_full;

   assign wr_data   = stlm_pkg::elem_type'(req_value);
   assign list_full = (cnt_ff[req_which_list] == stlm_pkg::cnt_type'(stlm_pkg::QUEUE_DEPTH));

   assign wr_en[0] = cmd.accept && !req_which_list && !ended_ff[0] && !req_only_end
                     && !list_full;
   assign wr_en[1] = cmd.accept && req_which_list && !ended_ff[1] && !req_only_end
                     && !list_full;

   stlm_ram #(
      .WIDTH (stlm_pkg::VALUE_WIDTH),
      .DEPTH (stlm_pkg::QUEUE_DEPTH)
   ) u_first_queue (
      .clock   (clock),
      .wr_en   (wr_en[0]),
      .wr_addr (wr_ff[0]),
      .wr_data (wr_data),
      .rd_addr (rd_ff[0]),
      .rd_data (head[0])
   );

   stlm_ram #(
      .WIDTH (stlm_pkg::VALUE_WIDTH),
      .DEPTH (stlm_pkg::QUEUE_DEPTH)
   ) u_second_queue (
      .clock   (clock),
      .wr_en   (wr_en[1]),
      .wr_addr (wr_ff[1]),
      .wr_data (wr_data),
      .rd_addr (rd_ff[1]),
      .rd_data (head[1])
   );

   assign has_a    = (cnt_ff[0] != '0);
   assign has_b    = (cnt_ff[1] != '0);
   assign can_emit = (has_a && has_b) || (has_a && ended_ff[1]) || (has_b && ended_ff[0]);
   assign close    = (ended_ff == 2'b11);
   assign out_free = !out_valid_ff || !rsp_stall;

   // tie goes to the second list
   always_comb begin
      priority if (has_a && has_b) begin
         src = !(head[0] < head[1]);
      end else if (has_a && ended_ff[1]) begin
         src = 1'b0;
      end else begin
         src = 1'b1;
      end
   end

   assign after_a        = src ? has_a : (cnt_ff[0] > stlm_pkg::cnt_type'(1));
   assign after_b        = src ? (cnt_ff[1] > stlm_pkg::cnt_type'(1)) : has_b;
   assign more_after_pop = (after_a && after_b) || (after_a && ended_ff[1])
                           || (after_b && ended_ff[0]);

   assign sts.out_free       = out_free;
   assign sts.has_pend       = (pend_ff != stlm_pkg::ST_ELEMENT);
   assign sts.can_emit       = can_emit;
   assign sts.close          = close;
   assign sts.more_after_pop = more_after_pop;

   always_comb begin
      rd_in         = rd_ff;
      wr_in         = wr_ff;
      cnt_in        = cnt_ff;
      ended_in      = ended_ff;
      pend_in       = pend_ff;
      out_valid_in  = out_valid_ff && rsp_stall;
      out_value_in  = out_value_ff;
      out_from_in   = out_from_ff;
      out_status_in = out_status_ff;
      out_done_in   = out_done_ff;
      out_last_in   = out_last_ff;

      if (cmd.accept) begin
         pend_in = stlm_pkg::ST_ELEMENT;
         priority if (ended_ff[req_which_list]) begin
            pend_in = stlm_pkg::ST_AFTER_END;
         end else if (req_only_end) begin
            ended_in[req_which_list] = 1'b1;
         end else begin
            if (list_full) begin
               pend_in = stlm_pkg::ST_DROPPED;
            end else begin
               wr_in[req_which_list]  = stlm_pkg::next_ptr(wr_ff[req_which_list]);
               cnt_in[req_which_list] = cnt_ff[req_which_list] + stlm_pkg::cnt_type'(1);
            end
            if (req_is_last) begin
               ended_in[req_which_list] = 1'b1;
            end
         end
      end

      if (cmd.send_status) begin
         pend_in       = stlm_pkg::ST_ELEMENT;
         out_valid_in  = 1'b1;
         out_value_in  = '0;
         out_from_in   = 1'b0;
         out_status_in = pend_ff;
         out_done_in   = 1'b0;
         out_last_in   = !can_emit && !close;
      end

      if (cmd.emit) begin
         out_valid_in  = 1'b1;
         out_value_in  = stlm_pkg::field_type'(head[src]);
         out_from_in   = src;
         out_status_in = stlm_pkg::ST_ELEMENT;
         out_done_in   = !more_after_pop && close;
         out_last_in   = !more_after_pop;
         rd_in[src]    = stlm_pkg::next_ptr(rd_ff[src]);
         cnt_in[src]   = cnt_ff[src] - stlm_pkg::cnt_type'(1);
         if (!more_after_pop && close) begin
            rd_in    = '{default: '0};
            wr_in    = '{default: '0};
            cnt_in   = '{default: '0};
            ended_in = '0;
         end
      end

      if (cmd.send_close) begin
         out_valid_in  = 1'b1;
         out_value_in  = '0;
         out_from_in   = 1'b0;
         out_status_in = stlm_pkg::ST_BOTH_EMPTY;
         out_done_in   = 1'b1;
         out_last_in   = 1'b1;
         rd_in         = '{default: '0};
         wr_in         = '{default: '0};
         cnt_in        = '{default: '0};
         ended_in      = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ff        <= '{default: '0};
         wr_ff        <= '{default: '0};
         cnt_ff       <= '{default: '0};
         ended_ff     <= '0;
         pend_ff      <= stlm_pkg::ST_ELEMENT;
         out_valid_ff <= 1'b0;
      end else begin
         rd_ff        <= rd_in;
         wr_ff        <= wr_in;
         cnt_ff       <= cnt_in;
         ended_ff     <= ended_in;
         pend_ff      <= pend_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_value_ff  <= out_value_in;
      out_from_ff   <= out_from_in;
      out_status_ff <= out_status_in;
      out_done_ff   <= out_done_in;
      out_last_ff   <= out_last_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_merged_value = out_value_ff;
   assign rsp_from_list    = out_from_ff;
   assign rsp_status       = out_status_ff;
   assign rsp_merge_done   = out_done_ff;
   assign rsp_run_last     = out_last_ff;

endmodule

`default_nettype wire

// ----- bench/sorted_two_list_merge_core_tb.sv -----
// testbench for sorted_two_list_merge_core: directed and random list pairs with
// random idling on both channels, every transfer checked against a local prediction
// depends on stlm_pkg and sorted_two_list_merge_core
module sorted_two_list_merge_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import stlm_pkg::*;

   localparam int HOLD_CYCLES  = 250;
   localparam int DRAIN_CYCLES = 12;
   localparam int VALS_WIDE    = 0;
   localparam int VALS_TIED    = 1;
   localparam int VALS_EDGE    = 2;
   localparam field_type MIN_VALUE = field_type'(32'h8000_0000);
   localparam field_type MAX_VALUE = field_type'(32'h7fff_ffff);

   typedef struct packed {
      field_type  merged_value;
      logic       from_list;
      status_type status;
      logic       merge_done;
      logic       run_last;
   } merge_out_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_which_list = 1'b0;
   field_type  req_value = '0;
   logic       req_is_last = 1'b0;
   logic       req_only_end = 1'b0;
   logic       rsp_stall = 1'b0;
   logic       req_stall;
   logic       rsp_valid;
   field_type  rsp_merged_value;
   logic       rsp_from_list;
   logic [1:0] rsp_status;
   logic       rsp_merge_done;
   logic       rsp_run_last;

   merge_out_type merged_due[$];
   elem_type      first_q[$];
   elem_type      second_q[$];
   logic [1:0]    lists_ended = 2'b00;

   int gap_pct = 30;
   int stall_pct = 77;
   int items_sent = 0;
   int failures = 0;
   int hold_asked = 0;
   int hold_seen = 0;
   int hold_left = 0;

   sorted_two_list_merge_core uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_which_list   (req_which_list),
      .req_value        (req_value),
      .req_is_last      (req_is_last),
      .req_only_end     (req_only_end),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_merged_value (rsp_merged_value),
      .rsp_from_list    (rsp_from_list),
      .rsp_status       (rsp_status),
      .rsp_merge_done   (rsp_merge_done),
      .rsp_run_last     (rsp_run_last)
   );

   always #2 clock = ~clock;

   function automatic merge_out_type status_out(input status_type code);
      merge_out_type r;
      r = '{merged_value: '0, from_list: 1'b0, status: code, merge_done: 1'b0,
            run_last: 1'b0};
      return r;
   endfunction

   function automatic void merge_step(input logic which, input field_type value,
                                      input logic is_last, input logic only_end);
      merge_out_type outs [0:2*QUEUE_DEPTH+1];
      int            n;
      int            i;
      logic          emitted;
      logic          src;
      elem_type      head;
      n = 0;
      emitted = 1'b0;
      if (lists_ended[which]) begin
         outs[n] = status_out(ST_AFTER_END);
         n++;
      end else if (only_end) begin
         lists_ended[which] = 1'b1;
      end else begin
         if ((which ? second_q.size() : first_q.size()) >= QUEUE_DEPTH) begin
            outs[n] = status_out(ST_DROPPED);
            n++;
         end else if (which) begin
            second_q.push_back(elem_type'(value));
         end else begin
            first_q.push_back(elem_type'(value));
         end
         if (is_last) begin
            lists_ended[which] = 1'b1;
         end
      end
      while (1'b1) begin
         if (first_q.size() > 0 && second_q.size() > 0) begin
            // tie goes to the second list
            src = (first_q[0] < second_q[0]) ? 1'b0 : 1'b1;
         end else if (first_q.size() > 0 && lists_ended[1]) begin
            src = 1'b0;
         end else if (second_q.size() > 0 && lists_ended[0]) begin
            src = 1'b1;
         end else begin
            break;
         end
         if (src) begin
            head = second_q.pop_front();
         end else begin
            head = first_q.pop_front();
         end
         outs[n] = status_out(ST_ELEMENT);
         outs[n].merged_value = field_type'(head);
         outs[n].from_list = src;
         n++;
         emitted = 1'b1;
      end
      if (lists_ended == 2'b11 && first_q.size() == 0 && second_q.size() == 0) begin
         if (!emitted) begin
            outs[n] = status_out(ST_BOTH_EMPTY);
            n++;
         end
         outs[n-1].merge_done = 1'b1;
         lists_ended = 2'b00;
      end
      if (n > 0) begin
         outs[n-1].run_last = 1'b1;
      end
      for (i = 0; i < n; i++) begin
         merged_due.push_back(outs[i]);
      end
   endfunction

   // result side: stall pattern and checking
   always @(negedge clock) begin
      if (hold_seen != hold_asked) begin
         hold_seen = hold_asked;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   always @(posedge clock) begin
      merge_out_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (merged_due.size() == 0) begin
            $error("unexpected transfer: merged_value %0d status %0d",
                   rsp_merged_value, rsp_status);
            failures++;
         end else begin
            want = merged_due.pop_front();
            if (rsp_merged_value !== want.merged_value) begin
               $error("merged_value: expected %0d, got %0d", want.merged_value,
                      rsp_merged_value);
               failures++;
            end
            if (rsp_from_list !== want.from_list) begin
               $error("from_list: expected %0d, got %0d", want.from_list, rsp_from_list);
               failures++;
            end
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_status);
               failures++;
            end
            if (rsp_merge_done !== want.merge_done) begin
               $error("merge_done: expected %0d, got %0d", want.merge_done,
                      rsp_merge_done);
               failures++;
            end
            if (rsp_run_last !== want.run_last) begin
               $error("run_last: expected %0d, got %0d", want.run_last, rsp_run_last);
               failures++;
            end
         end
      end
   end

   task automatic send_item(input logic which, input field_type value,
                            input logic is_last, input logic only_end);
      @(negedge clock);
      while ($urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_which_list <= which;
      req_value <= value;
      req_is_last <= is_last;
      req_only_end <= only_end;
      do begin
         @(posedge clock);
      end while (req_stall);
      merge_step(which, value, is_last, only_end);
      items_sent++;
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (merged_due.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic int draw_value(input int mode);
      int v;
      if (mode == VALS_WIDE) begin
         v = int'($urandom);
      end else if (mode == VALS_TIED) begin
         v = int'($urandom_range(15)) - 8;
      end else begin
         case ($urandom_range(4))
            0:       v = int'(MIN_VALUE);
            1:       v = int'(MAX_VALUE);
            2:       v = -1;
            3:       v = 0;
            default: v = int'($urandom);
         endcase
      end
      return v;
   endfunction

   function automatic int pick_len();
      int len;
      if ($urandom_range(19) == 0) begin
         len = int'($urandom_range(20, 12));
      end else begin
         len = int'($urandom_range(6));
      end
      return len;
   endfunction

   // one pair of lists, randomly interleaved, ending either on the last element
   // or with a separate end mark; now and then an item for a list already ended
   task automatic send_merge(input int len_a, input int len_b, input int mode,
                             input bit unsorted);
      int vals [0:1][$];
      int lens [0:1];
      int pos [0:1];
      bit sep [0:1];
      bit done [0:1];
      int s;
      int i;
      lens[0] = len_a;
      lens[1] = len_b;
      for (s = 0; s < 2; s++) begin
         pos[s] = 0;
         done[s] = 1'b0;
         sep[s] = (lens[s] == 0) || ($urandom_range(3) == 0);
         for (i = 0; i < lens[s]; i++) begin
            vals[s].push_back(draw_value(mode));
         end
         if (!unsorted) begin
            vals[s].sort();
         end
      end
      while (!done[0] || !done[1]) begin
         if (done[0]) begin
            s = 1;
         end else if (done[1]) begin
            s = 0;
         end else begin
            s = int'($urandom_range(1));
         end
         if (done[1-s] && $urandom_range(7) == 0) begin
            send_item(1'(1 - s), field_type'($urandom), 1'($urandom_range(1)),
                      1'($urandom_range(1)));
         end
         if (pos[s] < lens[s]) begin
            send_item(1'(s), field_type'(vals[s][pos[s]]),
                      !sep[s] && pos[s] == lens[s] - 1, 1'b0);
            pos[s]++;
            if (!sep[s] && pos[s] == lens[s]) begin
               done[s] = 1'b1;
            end
         end else begin
            send_item(1'(s), field_type'($urandom), 1'($urandom_range(1)), 1'b1);
            done[s] = 1'b1;
         end
      end
   endtask

   task automatic test_empty_lists();
      send_item(1'b0, '0, 1'b0, 1'b1);
      send_item(1'b1, MAX_VALUE, 1'b1, 1'b1);
      wait_drained();
   endtask

   task automatic test_value_extremes();
      send_item(1'b0, MIN_VALUE, 1'b0, 1'b0);
      send_item(1'b1, MIN_VALUE, 1'b0, 1'b0);
      send_item(1'b1, MAX_VALUE, 1'b1, 1'b0);
      send_item(1'b0, MAX_VALUE, 1'b1, 1'b0);
      wait_drained();
   endtask

   task automatic test_after_end();
      send_item(1'b0, field_type'(5), 1'b1, 1'b0);
      send_item(1'b0, field_type'(-5), 1'b0, 1'b0);
      send_item(1'b0, '0, 1'b0, 1'b1);
      send_item(1'b1, field_type'(7), 1'b1, 1'b0);
      wait_drained();
   endtask

   task automatic test_full_queue();
      int i;
      // the last element finds its queue full but still ends the list
      for (i = 0; i <= QUEUE_DEPTH; i++) begin
         send_item(1'b0, field_type'(i * 3 - 20), i == QUEUE_DEPTH, 1'b0);
      end
      send_item(1'b1, '0, 1'b0, 1'b1);
      wait_drained();
   endtask

   task automatic test_random_merges(input int gap, input int stall, input int n_items);
      int stop;
      stop = items_sent + n_items;
      gap_pct = gap;
      stall_pct = stall;
      while (items_sent < stop) begin
         if ($urandom_range(11) == 0) begin
            send_item(1'($urandom_range(1)), field_type'($urandom),
                      1'($urandom_range(1)), 1'($urandom_range(1)));
         end else begin
            send_merge(pick_len(), pick_len(), int'($urandom_range(VALS_EDGE)),
                       $urandom_range(9) == 0);
         end
      end
      wait_drained();
   endtask

   task automatic test_output_hold();
      gap_pct = 0;
      stall_pct = 0;
      hold_asked++;
      send_merge(14, 14, VALS_WIDE, 1'b0);
      send_merge(6, 9, VALS_TIED, 1'b0);
      wait_drained();
   endtask

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_empty_lists();
      test_value_extremes();
      test_after_end();
      test_full_queue();
      test_random_merges(30, 77, 120);
      test_random_merges(77, 30, 120);
      test_random_merges(0, 0, 120);
      test_output_hold();
      if (merged_due.size() != 0) begin
         $error("%0d expected transfers never arrived", merged_due.size());
      end
      if (failures == 0 && merged_due.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

// ----- sim.f -----
hw/rtl/stlm_pkg.sv
hw/rtl/stlm_ram.sv
hw/rtl/stlm_ctrl.sv
hw/rtl/stlm_datapath.sv
hw/rtl/sorted_two_list_merge_core.sv
bench/sorted_two_list_merge_core_tb.sv
